[src/lap_pkg.sv]
`timescale 1ns / 1ps

package lap_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int PAIR_W = 2 * PIX_W;
  localparam int WIN_N  = 9;

  localparam int GAIN_W   = 6;
  localparam int IWIDTH_W = 11;
  localparam int HEIGHT_W = 16;
  localparam int OCOL_W   = 10;

  // kernel sum spans -2040..2040, product with gain spans about +-128k
  localparam int SUM_W  = 12;
  localparam int PROD_W = SUM_W + GAIN_W + 1;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic                MODE_RST   = 1'b1;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 6'd1;
  localparam logic [IWIDTH_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd768;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_GAIN   = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic ld_sum;
    logic ld_prod;
  } lane_ctl_t;

endpackage

[src/lap_line_buf.sv]
`timescale 1ns / 1ps

module lap_line_buf #(
  parameter int DEPTH  = lap_pkg::MAX_WIDTH_DEF,
  parameter int AW     = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [lap_pkg::PAIR_W-1:0]  rd_data_o,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [lap_pkg::PAIR_W-1:0]  wr_data_i
);

  // upper line in the high half, middle line in the low half
  logic [lap_pkg::PAIR_W-1:0] mem [DEPTH];
  logic [lap_pkg::PAIR_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/lap_lane.sv]
`timescale 1ns / 1ps

module lap_lane (
  input  logic                        clk_i,
  input  lap_pkg::lane_ctl_t          ctl_i,
  input  logic                        mode_i,
  input  logic [lap_pkg::GAIN_W-1:0]  gain_i,
  input  logic [lap_pkg::CH_W-1:0]    win_i [lap_pkg::WIN_N],
  output logic [lap_pkg::CH_W-1:0]    result_o
);

  logic [9:0]                          sides;
  logic [9:0]                          corners;
  logic signed [lap_pkg::SUM_W-1:0]    sum_d;
  logic signed [lap_pkg::SUM_W-1:0]    sum_q;
  logic signed [lap_pkg::PROD_W-1:0]   prod_d;
  logic signed [lap_pkg::PROD_W-1:0]   prod_q;

  always_comb begin
    sides   = 10'(win_i[1]) + 10'(win_i[3]) + 10'(win_i[5]) + 10'(win_i[7]);
    corners = 10'(win_i[0]) + 10'(win_i[2]) + 10'(win_i[6]) + 10'(win_i[8]);
    if (mode_i) begin
      sum_d = $signed({1'b0, win_i[4], 3'b000}) - $signed({2'b00, sides})
              - $signed({2'b00, corners});
    end else begin
      sum_d = $signed({2'b00, win_i[4], 2'b00}) - $signed({2'b00, sides});
    end
  end

  assign prod_d = lap_pkg::PROD_W'(sum_q) * lap_pkg::PROD_W'($signed({1'b0, gain_i}));

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_sum) begin
      sum_q <= sum_d;
    end
    if (ctl_i.ld_prod) begin
      prod_q <= prod_d;
    end
  end

  // clamp to 0..255
  always_comb begin
    priority if (prod_q[lap_pkg::PROD_W-1]) begin
      result_o = '0;
    end else if (prod_q > $signed(lap_pkg::PROD_W'(255))) begin
      result_o = '1;
    end else begin
      result_o = prod_q[lap_pkg::CH_W-1:0];
    end
  end

endmodule

[src/laplacian_filter_3x3_rgb.sv]
`timescale 1ns / 1ps
// out_valid_o rises once the pixel completing a window has left stage 1, window, lane sum and product.
// Throughput: one pixel per cycle while out_stall_i allows; each channel has its own kernel/gain lane.
// The line store is one memory port pair, read on accept and written as stage 1 moves into the window.
// Reset clears counters, window, valid bits and config registers; line stores are not cleared
// and hold whatever they held until written.

module laplacian_filter_3x3_rgb #(
  parameter int MAX_WIDTH = lap_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lap_pkg::ADDR_W-1:0]      paddr,
  input  logic [lap_pkg::DATA_W-1:0]      pwdata,
  output logic [lap_pkg::DATA_W-1:0]      prdata,
  output logic                            pready,

  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [lap_pkg::CH_W-1:0]        in_red_i,
  input  logic [lap_pkg::CH_W-1:0]        in_green_i,
  input  logic [lap_pkg::CH_W-1:0]        in_blue_i,

  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lap_pkg::CH_W-1:0]        out_red_o,
  output logic [lap_pkg::CH_W-1:0]        out_green_o,
  output logic [lap_pkg::CH_W-1:0]        out_blue_o,
  output logic [lap_pkg::OCOL_W-1:0]      out_column_o,
  output logic [lap_pkg::HEIGHT_W-1:0]    out_line_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > lap_pkg::IWIDTH_W) ? CW + 1 : lap_pkg::IWIDTH_W;
  localparam int HW = lap_pkg::HEIGHT_W;
  localparam int PW = lap_pkg::PIX_W;

  // configuration registers
  logic                            mode_q;
  logic [lap_pkg::GAIN_W-1:0]      gain_q;
  logic [lap_pkg::IWIDTH_W-1:0]    width_q;
  logic [HW-1:0]                   height_q;
  logic                            cfg_wr;
  lap_pkg::reg_idx_e               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = lap_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= lap_pkg::MODE_RST;
      gain_q   <= lap_pkg::GAIN_RST;
      width_q  <= lap_pkg::WIDTH_RST;
      height_q <= lap_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lap_pkg::REG_MODE:   mode_q   <= pwdata[0];
        lap_pkg::REG_GAIN:   gain_q   <= pwdata[lap_pkg::GAIN_W-1:0];
        lap_pkg::REG_WIDTH:  width_q  <= pwdata[lap_pkg::IWIDTH_W-1:0];
        lap_pkg::REG_HEIGHT: height_q <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lap_pkg::REG_MODE:   prdata = lap_pkg::DATA_W'(mode_q);
      lap_pkg::REG_GAIN:   prdata = lap_pkg::DATA_W'(gain_q);
      lap_pkg::REG_WIDTH:  prdata = lap_pkg::DATA_W'(width_q);
      lap_pkg::REG_HEIGHT: prdata = lap_pkg::DATA_W'(height_q);
      default:             prdata = '0;
    endcase
  end

  // handshake: each stage moves when the one after it is empty or moving; stage 2 drops non-emitting windows
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic emit1_q, emit2_q;
  logic f_out, f4, f3, f2, f1;
  logic move1, move2, move3, move4, accept;

  assign f_out  = !vo_q || !out_stall_i;
  assign f4     = !v4_q || f_out;
  assign f3     = !v3_q || f4;
  assign f2     = !v2_q || !emit2_q || f3;
  assign f1     = !v1_q || f2;
  assign move1  = v1_q && f2;
  assign move2  = v2_q && emit2_q && f3;
  assign move3  = v3_q && f4;
  assign move4  = v4_q && f_out;
  assign accept = in_valid_i && f1;
  assign in_stall_o = !f1;

  // raster counters
  logic [CW-1:0] col_q;
  logic [HW-1:0] line_q;
  logic [EW-1:0] width_ext, eff_width, col_inc;
  logic [HW:0]   eff_height, line_inc;
  logic          emit_now;

  always_comb begin
    width_ext = EW'(width_q);
    priority if (width_ext < EW'(3)) begin
      eff_width = EW'(3);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      eff_width = EW'(MAX_WIDTH);
    end else begin
      eff_width = width_ext;
    end
    eff_height = (height_q < HW'(3)) ? (HW + 1)'(3) : {1'b0, height_q};
    col_inc    = EW'(col_q) + EW'(1);
    line_inc   = {1'b0, line_q} + (HW + 1)'(1);
    emit_now   = (line_q >= HW'(2)) && (col_q >= CW'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
    end else if (accept) begin
      if (col_inc >= eff_width) begin
        col_q  <= '0;
        line_q <= (line_inc >= eff_height) ? '0 : line_q + HW'(1);
      end else begin
        col_q  <= col_q + CW'(1);
      end
    end
  end

  // stage 1: pixel waits for the line store read
  logic [PW-1:0]             pix1_q;
  logic [CW-1:0]             col1_q, col2_q;
  logic [HW-1:0]             line1_q, line2_q;
  logic [lap_pkg::PAIR_W-1:0] rd_data;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix1_q  <= {in_red_i, in_green_i, in_blue_i};
      col1_q  <= col_q;
      line1_q <= line_q;
      emit1_q <= emit_now;
    end
  end

  lap_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (move1),
    .wr_addr_i (col1_q),
    .wr_data_i ({rd_data[PW-1:0], pix1_q})
  );

  // stage 2: window, rows upper / middle / newest, shift left
  logic [PW-1:0] win_q [lap_pkg::WIN_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lap_pkg::WIN_N; i++) begin
        win_q[i] <= '0;
      end
    end else if (move1) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= rd_data[lap_pkg::PAIR_W-1:PW];
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= rd_data[PW-1:0];
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= pix1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move1) begin
      col2_q  <= col1_q;
      line2_q <= line1_q;
      emit2_q <= emit1_q;
    end
  end

  // lanes, one per channel
  logic [lap_pkg::CH_W-1:0] red_w [lap_pkg::WIN_N];
  logic [lap_pkg::CH_W-1:0] grn_w [lap_pkg::WIN_N];
  logic [lap_pkg::CH_W-1:0] blu_w [lap_pkg::WIN_N];
  logic [lap_pkg::CH_W-1:0] red_res, grn_res, blu_res;
  lap_pkg::lane_ctl_t       lane_ctl;

  always_comb begin
    for (int i = 0; i < lap_pkg::WIN_N; i++) begin
      red_w[i] = win_q[i][PW-1:2*lap_pkg::CH_W];
      grn_w[i] = win_q[i][2*lap_pkg::CH_W-1:lap_pkg::CH_W];
      blu_w[i] = win_q[i][lap_pkg::CH_W-1:0];
    end
  end

  assign lane_ctl.ld_sum  = move2;
  assign lane_ctl.ld_prod = move3;

  lap_lane u_lane_red (
    .clk_i (clk_i), .ctl_i (lane_ctl), .mode_i (mode_q), .gain_i (gain_q),
    .win_i (red_w), .result_o (red_res)
  );

  lap_lane u_lane_green (
    .clk_i (clk_i), .ctl_i (lane_ctl), .mode_i (mode_q), .gain_i (gain_q),
    .win_i (grn_w), .result_o (grn_res)
  );

  lap_lane u_lane_blue (
    .clk_i (clk_i), .ctl_i (lane_ctl), .mode_i (mode_q), .gain_i (gain_q),
    .win_i (blu_w), .result_o (blu_res)
  );

  // coordinates of the window centre follow the lanes
  logic [EW-1:0]              col_dec;
  logic [lap_pkg::OCOL_W-1:0] col3_q, col4_q, col_out_q;
  logic [HW-1:0]              line3_q, line4_q, line_out_q;
  logic [lap_pkg::CH_W-1:0]   red_q, grn_q, blu_q;

  assign col_dec = EW'(col2_q) - EW'(1);

  always_ff @(posedge clk_i) begin
    if (move2) begin
      col3_q  <= col_dec[lap_pkg::OCOL_W-1:0];
      line3_q <= line2_q - HW'(1);
    end
    if (move3) begin
      col4_q  <= col3_q;
      line4_q <= line3_q;
    end
    // merge the three lanes into one output word
    if (move4) begin
      red_q      <= red_res;
      grn_q      <= grn_res;
      blu_q      <= blu_res;
      col_out_q  <= col4_q;
      line_out_q <= line4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (accept) begin
        v1_q <= 1'b1;
      end else if (move1) begin
        v1_q <= 1'b0;
      end
      if (move1) begin
        v2_q <= 1'b1;
      end else if (v2_q && f2) begin
        v2_q <= 1'b0;
      end
      if (move2) begin
        v3_q <= 1'b1;
      end else if (move3) begin
        v3_q <= 1'b0;
      end
      if (move3) begin
        v4_q <= 1'b1;
      end else if (move4) begin
        v4_q <= 1'b0;
      end
      if (move4) begin
        vo_q <= 1'b1;
      end else if (!out_stall_i) begin
        vo_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = vo_q;
  assign out_red_o    = red_q;
  assign out_green_o  = grn_q;
  assign out_blue_o   = blu_q;
  assign out_column_o = col_out_q;
  assign out_line_o   = line_out_q;

endmodule

[verif/laplacian_filter_3x3_rgb_tb.sv]
`timescale 1ns / 1ps

module laplacian_filter_3x3_rgb_tb;

  localparam int SETTLE_CYCLES = 12;
  localparam int RESET_PIXELS  = 200;
  localparam int RANDOM_PIXELS = 850;

  typedef struct packed {
    logic [lap_pkg::CH_W-1:0]     red;
    logic [lap_pkg::CH_W-1:0]     green;
    logic [lap_pkg::CH_W-1:0]     blue;
    logic [lap_pkg::OCOL_W-1:0]   column;
    logic [lap_pkg::HEIGHT_W-1:0] line_no;
  } laplace_result_t;

  class laplace_scoreboard;
    logic [lap_pkg::PIX_W-1:0] upper_line [lap_pkg::MAX_WIDTH_DEF];
    logic [lap_pkg::PIX_W-1:0] middle_line [lap_pkg::MAX_WIDTH_DEF];
    logic [lap_pkg::PIX_W-1:0] window [lap_pkg::WIN_N];
    int col, row;
    bit eight_nbr;
    int gain, width_reg, height_reg;
    laplace_result_t expected_q [$];
    int errors, pixels_seen, results_seen;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      col = 0;
      row = 0;
      eight_nbr = lap_pkg::MODE_RST;
      gain = int'(lap_pkg::GAIN_RST);
      width_reg = int'(lap_pkg::WIDTH_RST);
      height_reg = int'(lap_pkg::HEIGHT_RST);
      errors = 0;
      pixels_seen = 0;
      results_seen = 0;
    endfunction

    function void write_reg(lap_pkg::reg_idx_e idx, logic [lap_pkg::DATA_W-1:0] value);
      case (idx)
        lap_pkg::REG_MODE:   eight_nbr = value[0];
        lap_pkg::REG_GAIN:   gain = int'(value[lap_pkg::GAIN_W-1:0]);
        lap_pkg::REG_WIDTH:  width_reg = int'(value[lap_pkg::IWIDTH_W-1:0]);
        lap_pkg::REG_HEIGHT: height_reg = int'(value[lap_pkg::HEIGHT_W-1:0]);
        default: ;
      endcase
    endfunction

    function int line_width();
      if (width_reg < 3) return 3;
      if (width_reg > lap_pkg::MAX_WIDTH_DEF) return lap_pkg::MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int frame_height();
      return (height_reg < 3) ? 3 : height_reg;
    endfunction

    function bit at_frame_start();
      return col == 0 && row == 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [lap_pkg::CH_W-1:0] lane(int sh);
      int centre, sides, corners, v;
      centre = int'(window[4][sh +: 8]);
      sides = int'(window[1][sh +: 8]) + int'(window[3][sh +: 8])
            + int'(window[5][sh +: 8]) + int'(window[7][sh +: 8]);
      corners = int'(window[0][sh +: 8]) + int'(window[2][sh +: 8])
              + int'(window[6][sh +: 8]) + int'(window[8][sh +: 8]);
      v = eight_nbr ? 8 * centre - sides - corners : 4 * centre - sides;
      v = v * gain;
      if (v < 0) v = 0;
      else if (v > 255) v = 255;
      return v[7:0];
    endfunction

    function void note_pixel(logic [lap_pkg::CH_W-1:0] r, logic [lap_pkg::CH_W-1:0] g,
                             logic [lap_pkg::CH_W-1:0] b);
      logic [lap_pkg::PIX_W-1:0] pix, up, mid;
      laplace_result_t res;
      pix = {r, g, b};
      up = upper_line[col];
      mid = middle_line[col];
      upper_line[col] = mid;
      middle_line[col] = pix;
      for (int i = 0; i < 3; i++) begin
        window[3*i] = window[3*i+1];
        window[3*i+1] = window[3*i+2];
        window[3*i+2] = (i == 0) ? up : (i == 1) ? mid : pix;
      end
      pixels_seen++;
      if (row >= 2 && col >= 2) begin
        res.red = lane(16);
        res.green = lane(8);
        res.blue = lane(0);
        res.column = lap_pkg::OCOL_W'(col - 1);
        res.line_no = lap_pkg::HEIGHT_W'(row - 1);
        expected_q.push_back(res);
      end
      // wrap at line end; a counter already past a shrunk width wraps here too
      if (col + 1 >= line_width()) begin
        col = 0;
        row = (row + 1 >= frame_height()) ? 0 : row + 1;
      end else begin
        col++;
      end
    endfunction

    function void check_result(laplace_result_t got);
      laplace_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $error("unexpected result word: column %0d line %0d", got.column, got.line_no);
        return;
      end
      want = expected_q.pop_front();
      results_seen++;
      if (got.red !== want.red) begin
        errors++;
        $error("out_red: expected %0d, got %0d", want.red, got.red);
      end
      if (got.green !== want.green) begin
        errors++;
        $error("out_green: expected %0d, got %0d", want.green, got.green);
      end
      if (got.blue !== want.blue) begin
        errors++;
        $error("out_blue: expected %0d, got %0d", want.blue, got.blue);
      end
      if (got.column !== want.column) begin
        errors++;
        $error("out_column: expected %0d, got %0d", want.column, got.column);
      end
      if (got.line_no !== want.line_no) begin
        errors++;
        $error("out_line: expected %0d, got %0d", want.line_no, got.line_no);
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [lap_pkg::ADDR_W-1:0]   paddr;
  logic [lap_pkg::DATA_W-1:0]   pwdata;
  logic [lap_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [lap_pkg::CH_W-1:0]     in_red_i;
  logic [lap_pkg::CH_W-1:0]     in_green_i;
  logic [lap_pkg::CH_W-1:0]     in_blue_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [lap_pkg::CH_W-1:0]     out_red_o;
  logic [lap_pkg::CH_W-1:0]     out_green_o;
  logic [lap_pkg::CH_W-1:0]     out_blue_o;
  logic [lap_pkg::OCOL_W-1:0]   out_column_o;
  logic [lap_pkg::HEIGHT_W-1:0] out_line_o;

  laplace_scoreboard sb;
  bit no_gaps;
  int reg_writes;
  int random_count;

  laplacian_filter_3x3_rgb DUT (.*);

  always #10ns clk_i = ~clk_i;

  function automatic int pick_gain();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 63;
      2: return $urandom_range(0, 63);
      default: return $urandom_range(1, 3);
    endcase
  endfunction

  function automatic logic [lap_pkg::CH_W-1:0] pick_chan(int base);
    int v;
    if ($urandom_range(0, 1)) return lap_pkg::CH_W'($urandom_range(0, 255));
    v = base + int'($urandom_range(0, 30)) - 15;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic send_pixel(input logic [lap_pkg::CH_W-1:0] r,
                            input logic [lap_pkg::CH_W-1:0] g,
                            input logic [lap_pkg::CH_W-1:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_red_i <= r;
    in_green_i <= g;
    in_blue_i <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_pixel(r, g, b);
  endtask

  task automatic send_noisy_pixel(input int base_r, input int base_g, input int base_b);
    send_pixel(pick_chan(base_r), pick_chan(base_g), pick_chan(base_b));
  endtask

  // hold the input until every pending result is out and the pipe is empty
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input lap_pkg::reg_idx_e idx,
                           input logic [lap_pkg::DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.write_reg(idx, value);
    reg_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_filter(input int mode, input int gain, input int w, input int h);
    apb_write(lap_pkg::REG_MODE, mode);
    apb_write(lap_pkg::REG_GAIN, gain);
    apb_write(lap_pkg::REG_WIDTH, w);
    apb_write(lap_pkg::REG_HEIGHT, h);
  endtask

  // directed 3x3 frame: raster index equals window index at the last pixel
  task automatic send_kernel_frame();
    for (int i = 0; i < lap_pkg::WIN_N; i++) begin
      send_pixel((i == 4) ? 8'd255 : 8'd0, (i == 4) ? 8'd0 : 8'd255,
                 (i == 4) ? 8'd100 : ((i % 2) ? 8'd90 : 8'd95));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      sb.check_result({out_red_o, out_green_o, out_blue_o, out_column_o, out_line_o});
    end
  end

  initial begin
    int hold;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  initial begin
    #25ms;
    $display("laplacian_filter_3x3_rgb_tb failed");
    $finish;
  end

  initial begin
    int base_r, base_g, base_b, split, n;
    sb = new();
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    in_red_i = '0;
    in_green_i = '0;
    in_blue_i = '0;
    no_gaps = 1'b0;
    reg_writes = 0;
    random_count = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // part of a full-width line under reset settings, then mid-frame changes end the frame
    no_gaps = 1'($urandom_range(0, 1));
    base_r = $urandom_range(0, 255);
    base_g = $urandom_range(0, 255);
    base_b = $urandom_range(0, 255);
    repeat (RESET_PIXELS) send_noisy_pixel(base_r, base_g, base_b);
    drain_results();
    apb_write(lap_pkg::REG_WIDTH, 2047);
    apb_write(lap_pkg::REG_MODE, 0);
    apb_write(lap_pkg::REG_GAIN, 63);
    repeat (20) send_noisy_pixel(base_r, base_g, base_b);
    drain_results();
    apb_write(lap_pkg::REG_WIDTH, 3);
    apb_write(lap_pkg::REG_HEIGHT, 4);
    do send_noisy_pixel(base_r, base_g, base_b); while (!sb.at_frame_start());

    // single-window frames: both kernels, clamp at both ends, undersized geometry
    drain_results();
    program_filter(0, 1, 0, 1);
    send_kernel_frame();
    drain_results();
    program_filter(1, 63, 2, 2);
    send_kernel_frame();
    drain_results();
    program_filter(1, 1, 3, 0);
    send_kernel_frame();

    // tallest frame setting, cut short by a height change
    drain_results();
    program_filter(1, 2, 5, 65535);
    repeat (35) send_noisy_pixel(base_r, base_g, base_b);
    drain_results();
    apb_write(lap_pkg::REG_HEIGHT, 1);
    do send_noisy_pixel(base_r, base_g, base_b); while (!sb.at_frame_start());

    while (random_count < RANDOM_PIXELS) begin
      drain_results();
      program_filter($urandom_range(0, 1), pick_gain(),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6));
      no_gaps = ($urandom_range(0, 3) == 0);
      base_r = $urandom_range(0, 255);
      base_g = $urandom_range(0, 255);
      base_b = $urandom_range(0, 255);
      split = ($urandom_range(0, 2) == 0) ?
              $urandom_range(1, sb.line_width() * sb.frame_height() - 1) : 0;
      n = 0;
      do begin
        if (split != 0 && n == split) begin
          // width may only shrink here so no stale line entry gets into a window
          drain_results();
          apb_write(lap_pkg::REG_MODE, $urandom_range(0, 1));
          apb_write(lap_pkg::REG_GAIN, pick_gain());
          apb_write(lap_pkg::REG_WIDTH, $urandom_range(0, sb.line_width()));
          apb_write(lap_pkg::REG_HEIGHT, $urandom_range(0, 8));
        end
        send_noisy_pixel(base_r, base_g, base_b);
        n++;
        random_count++;
      end while (!sb.at_frame_start());
    end

    drain_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d pixels, checked %0d filtered words, made %0d register writes.",
             sb.pixels_seen, sb.results_seen, reg_writes);
    $display("Run covered reset settings, both kernels, clamped sizes and mid-frame changes.");
    if (sb.errors == 0) begin
      $display("laplacian_filter_3x3_rgb_tb passed");
    end else begin
      $display("laplacian_filter_3x3_rgb_tb failed");
    end
    $finish;
  end

endmodule
